// ----- design/hhrf_pkg.sv -----
// Shared widths, types and register codes for the flat-bottom restraint force block.
// No dependencies; every design file imports it.
package hhrf_pkg;

    localparam int CRD_W   = 32;           // coordinate, signed Q16.16
    localparam int DLT_W   = CRD_W + 1;    // exact difference
    localparam int SQ_W    = 66;           // sum of three squares
    localparam int ROOT_W  = 34;           // floor square root
    localparam int QUO_W   = 30;           // ratio bits, Q0.30 below one
    localparam int K_W     = 32;
    localparam int L_W     = 31;
    localparam int SCL_W   = 24;
    localparam int A_W     = DLT_W + SCL_W;  // |d| * scale
    localparam int KQ_W    = 63;             // 2k * q
    localparam int OUT_W   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [SCL_W-1:0] SCALE_ONE = SCL_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FORCE_CONSTANT = 2'd0,
        CFG_FLAT_LENGTH    = 2'd1,
        CFG_FORCE_SCALE    = 2'd2,
        CFG_UNUSED         = 2'd3
    } t_cfg_idx;

endpackage

// ----- design/half_harmonic_restraint_force.sv -----
// Top level of the flat-bottom harmonic distance restraint: energy and force on one point pair.
// Depends on hhrf_pkg, hhrf_sqrt and hhrf_div.
//
// Usage:
//   A point pair is taken at a clock edge with start high and busy low. busy is
//   high during reset and in the cycle after it; from then on a pair is taken every cycle.
//   Each pair gives one result: o_done is high for one cycle with the energy,
//   the three force components on the second point and the saturation flag.
//   From the accepting edge to o_done a pair passes the difference, squares and
//   scaling registers, 34 square-root stages (one root bit each), the flat-length
//   compare register, 30 divider stages (one ratio bit each) and the U1 to U5
//   stages of wide multiply, add and saturation.
//   Throughput is one pair per cycle; every stage is a register slice.
//   The result receiver cannot stall, and the pipeline never holds.
//   Configuration writes (i_cfg_valid/o_cfg_ready) are taken in any cycle after
//   reset and must only happen with no transaction in flight.
//   Reset clears the stage valid bits and loads k = 0, L = 0, scale = 1.0.
module half_harmonic_restraint_force (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_first_x,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_first_y,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_first_z,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_second_x,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_second_y,
    input  logic signed [hhrf_pkg::CRD_W-1:0]   i_second_z,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hhrf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [hhrf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_done,
    output logic [hhrf_pkg::OUT_W-1:0]          o_restraint_energy,
    output logic signed [hhrf_pkg::OUT_W-1:0]   o_push_x,
    output logic signed [hhrf_pkg::OUT_W-1:0]   o_push_y,
    output logic signed [hhrf_pkg::OUT_W-1:0]   o_push_z,
    output logic                                o_saturated
);
    import hhrf_pkg::*;

    localparam int LATENCY = 73;
    localparam int PRD_W   = A_W + KQ_W;     // 120
    localparam int EPR_W   = K_W + SQ_W;     // 98
    localparam int EHALF_W = SQ_W / 2;       // 33

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][A_W-1:0]   a;
        logic [SQ_W-1:0]       s;
    } t_sqrt_side;

    typedef struct packed {
        logic [2:0]            neg;
        logic [2:0][A_W-1:0]   a;
        logic [SQ_W-1:0]       s;
        logic [ROOT_W-1:0]     e;
        logic                  harm;
        logic                  flat;
    } t_div_side;

    // ---------------- configuration ----------------
    logic             r_ready;
    logic [K_W-1:0]   r_k;
    logic [L_W-1:0]   r_len;
    logic [SCL_W-1:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_k     <= '0;
            r_len   <= '0;
            r_scale <= SCALE_ONE;
        end else begin
            r_ready <= 1'b1;
            if (i_cfg_valid && r_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_FORCE_CONSTANT: r_k     <= i_cfg_data;
                    CFG_FLAT_LENGTH:    r_len   <= i_cfg_data[L_W-1:0];
                    CFG_FORCE_SCALE:    r_scale <= i_cfg_data[SCL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign busy        = !r_ready;
    assign o_cfg_ready = r_ready;

    // ---------------- stage 0: differences ----------------
    logic                          r_s0_vld;
    logic [2:0][DLT_W-1:0]         r_s0_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else begin
            r_s0_vld <= start && !busy;
        end
        r_s0_d[0] <= {i_second_x[CRD_W-1], i_second_x} - {i_first_x[CRD_W-1], i_first_x};
        r_s0_d[1] <= {i_second_y[CRD_W-1], i_second_y} - {i_first_y[CRD_W-1], i_first_y};
        r_s0_d[2] <= {i_second_z[CRD_W-1], i_second_z} - {i_first_z[CRD_W-1], i_first_z};
    end

    // ---------------- stage 1: magnitudes and squares ----------------
    logic                          r_s1_vld;
    logic [2:0]                    r_s1_neg;
    logic [2:0][DLT_W-1:0]         r_s1_mag;
    logic [2:0][2*DLT_W-1:0]       r_s1_sq;
    logic [2:0][DLT_W-1:0]         w_mag;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            w_mag[l] = r_s0_d[l][DLT_W-1] ? DLT_W'(-r_s0_d[l]) : r_s0_d[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= r_s0_vld;
        end
        for (int l = 0; l < 3; l++) begin
            r_s1_neg[l] <= r_s0_d[l][DLT_W-1];
            r_s1_mag[l] <= w_mag[l];
            r_s1_sq[l]  <= w_mag[l] * w_mag[l];
        end
    end

    // ---------------- stage 2: sum of squares, scaled magnitudes ----------------
    logic       r_s2_vld;
    t_sqrt_side r_s2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_side.neg <= r_s1_neg;
        r_s2_side.s   <= r_s1_sq[0] + r_s1_sq[1] + r_s1_sq[2];
        for (int l = 0; l < 3; l++) begin
            r_s2_side.a[l] <= r_s1_mag[l] * r_scale;
        end
    end

    // ---------------- square root ----------------
    logic              w_rt_vld;
    logic [ROOT_W-1:0] w_rt_root;
    t_sqrt_side        w_rt_side;

    hhrf_sqrt #(
        .SIDE_W ($bits(t_sqrt_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s2_vld),
        .i_sq    (r_s2_side.s),
        .i_side  (r_s2_side),
        .o_vld   (w_rt_vld),
        .o_root  (w_rt_root),
        .o_side  (w_rt_side)
    );

    // ---------------- flat-length compare ----------------
    logic              r_t1_vld;
    logic [ROOT_W-1:0] r_t1_root;
    t_div_side         r_t1_side;
    logic              w_harm;
    logic              w_flat;

    assign w_harm = (r_len == '0);
    assign w_flat = !w_harm && (w_rt_root > ROOT_W'(r_len));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1_vld <= 1'b0;
        end else begin
            r_t1_vld <= w_rt_vld;
        end
        r_t1_root      <= w_rt_root;
        r_t1_side.neg  <= w_rt_side.neg;
        r_t1_side.a    <= w_rt_side.a;
        r_t1_side.s    <= w_rt_side.s;
        r_t1_side.harm <= w_harm;
        r_t1_side.flat <= w_flat;
        // excess only feeds the divider when the root exceeds the flat length, else zero
        r_t1_side.e    <= w_flat ? w_rt_root - ROOT_W'(r_len) : '0;
    end

    // ---------------- ratio e / r ----------------
    logic             w_dv_vld;
    logic [QUO_W-1:0] w_dv_quo;
    t_div_side        w_dv_side;

    hhrf_div #(
        .SIDE_W ($bits(t_div_side))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_t1_vld),
        .i_num   (r_t1_side.e),
        .i_den   (r_t1_root),
        .i_side  (r_t1_side),
        .o_vld   (w_dv_vld),
        .o_quo   (w_dv_quo),
        .o_side  (w_dv_side)
    );

    // ---------------- U1: 2k*q and e^2 ----------------
    logic                r_u1_vld;
    logic [KQ_W-1:0]     r_u1_kq;
    logic [SQ_W-1:0]     r_u1_esq;
    logic [SQ_W-1:0]     r_u1_s;
    logic                r_u1_harm;
    logic                r_u1_flat;
    logic [2:0]          r_u1_neg;
    logic [2:0][A_W-1:0] r_u1_a;
    logic [QUO_W:0]      w_q;
    logic [2*K_W:0]      w_kq_full;
    logic [2*ROOT_W-1:0] w_esq_full;

    always_comb begin
        priority if (w_dv_side.harm) begin
            w_q = (QUO_W+1)'(1) << QUO_W;
        end else if (w_dv_side.flat) begin
            w_q = {1'b0, w_dv_quo};
        end else begin
            w_q = '0;
        end
    end

    assign w_kq_full  = {r_k, 1'b0} * w_q;
    assign w_esq_full = w_dv_side.e * w_dv_side.e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u1_vld <= 1'b0;
        end else begin
            r_u1_vld <= w_dv_vld;
        end
        r_u1_kq   <= w_kq_full[KQ_W-1:0];
        r_u1_esq  <= w_esq_full[SQ_W-1:0];
        r_u1_s    <= w_dv_side.s;
        r_u1_harm <= w_dv_side.harm;
        r_u1_flat <= w_dv_side.flat;
        r_u1_neg  <= w_dv_side.neg;
        r_u1_a    <= w_dv_side.a;
    end

    // ---------------- U2: partial products ----------------
    logic                     r_u2_vld;
    logic [K_W+EHALF_W-1:0]   r_u2_pe_lo;
    logic [K_W+EHALF_W-1:0]   r_u2_pe_hi;
    logic [2:0]               r_u2_neg;
    logic [2:0][63:0]         r_u2_ll;
    logic [2:0][62:0]         r_u2_lh;
    logic [2:0][56:0]         r_u2_hl;
    logic [2:0][55:0]         r_u2_hh;
    logic [SQ_W-1:0]          w_e_sel;

    always_comb begin
        priority if (r_u1_harm) begin
            w_e_sel = r_u1_s;
        end else if (r_u1_flat) begin
            w_e_sel = r_u1_esq;
        end else begin
            w_e_sel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u2_vld <= 1'b0;
        end else begin
            r_u2_vld <= r_u1_vld;
        end
        r_u2_pe_lo <= r_k * w_e_sel[EHALF_W-1:0];
        r_u2_pe_hi <= r_k * w_e_sel[SQ_W-1:EHALF_W];
        r_u2_neg   <= r_u1_neg;
        for (int l = 0; l < 3; l++) begin
            r_u2_ll[l] <= r_u1_a[l][31:0]      * r_u1_kq[31:0];
            r_u2_lh[l] <= r_u1_a[l][31:0]      * r_u1_kq[KQ_W-1:32];
            r_u2_hl[l] <= r_u1_a[l][A_W-1:32]  * r_u1_kq[31:0];
            r_u2_hh[l] <= r_u1_a[l][A_W-1:32]  * r_u1_kq[KQ_W-1:32];
        end
    end

    // ---------------- U3: energy sum, cross terms ----------------
    logic                r_u3_vld;
    logic [OUT_W-1:0]    r_u3_energy;
    logic                r_u3_esat;
    logic [2:0]          r_u3_neg;
    logic [2:0][63:0]    r_u3_ll;
    logic [2:0][64:0]    r_u3_mid;
    logic [2:0][55:0]    r_u3_hh;
    logic [EPR_W-1:0]    w_eprod;
    logic                w_esat;

    assign w_eprod = EPR_W'(r_u2_pe_lo) + (EPR_W'(r_u2_pe_hi) << EHALF_W);
    assign w_esat  = |w_eprod[EPR_W-1:OUT_W+32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u3_vld <= 1'b0;
        end else begin
            r_u3_vld <= r_u2_vld;
        end
        r_u3_esat   <= w_esat;
        r_u3_energy <= w_esat ? '1 : w_eprod[OUT_W+31:32];
        r_u3_neg    <= r_u2_neg;
        for (int l = 0; l < 3; l++) begin
            r_u3_ll[l]  <= r_u2_ll[l];
            r_u3_mid[l] <= 65'(r_u2_lh[l]) + 65'(r_u2_hl[l]);
            r_u3_hh[l]  <= r_u2_hh[l];
        end
    end

    // ---------------- U4: full force products ----------------
    logic                   r_u4_vld;
    logic [OUT_W-1:0]       r_u4_energy;
    logic                   r_u4_esat;
    logic [2:0]             r_u4_neg;
    logic [2:0][PRD_W-1:0]  r_u4_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_u4_vld <= 1'b0;
        end else begin
            r_u4_vld <= r_u3_vld;
        end
        r_u4_energy <= r_u3_energy;
        r_u4_esat   <= r_u3_esat;
        r_u4_neg    <= r_u3_neg;
        for (int l = 0; l < 3; l++) begin
            r_u4_prod[l] <= PRD_W'(r_u3_ll[l]) + (PRD_W'(r_u3_mid[l]) << 32)
                          + (PRD_W'(r_u3_hh[l]) << 64);
        end
    end

    // ---------------- U5: scale down, clip, sign ----------------
    logic                   r_done;
    logic [OUT_W-1:0]       r_energy;
    logic [2:0][OUT_W-1:0]  r_push;
    logic                   r_sat;
    logic [2:0][OUT_W:0]    w_mag_f;
    logic [2:0][OUT_W:0]    w_clip;
    logic [2:0][OUT_W-1:0]  w_push;
    logic [2:0]             w_fsat;

    always_comb begin
        for (int l = 0; l < 3; l++) begin
            logic [OUT_W:0] lim;
            lim = r_u4_neg[l] ? ((OUT_W+1)'(1) << (OUT_W-1))
                              : ((OUT_W+1)'(1) << (OUT_W-1)) - (OUT_W+1)'(1);
            if (|r_u4_prod[l][PRD_W-1:OUT_W+62]) begin
                w_mag_f[l] = (OUT_W+1)'(1) << OUT_W;
            end else begin
                w_mag_f[l] = {1'b0, r_u4_prod[l][OUT_W+61:62]};
            end
            w_fsat[l] = (w_mag_f[l] > lim);
            w_clip[l] = w_fsat[l] ? lim : w_mag_f[l];
            w_push[l] = r_u4_neg[l] ? OUT_W'(-w_clip[l]) : w_clip[l][OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_u4_vld;
        end
        r_energy <= r_u4_energy;
        r_push   <= w_push;
        r_sat    <= r_u4_esat || (|w_fsat);
    end

    assign o_done             = r_done;
    assign o_restraint_energy = r_energy;
    assign o_push_x           = r_push[0];
    assign o_push_y           = r_push[1];
    assign o_push_z           = r_push[2];
    assign o_saturated        = r_sat;

    // ---------------- checks ----------------
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> busy && !o_done && !o_cfg_ready)
        else $error("block not quiet after reset");

    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LATENCY o_done)
        else $error("accepted transaction produced no result at fixed latency");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without matching accepted transaction");

endmodule

// ----- design/hhrf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on hhrf_pkg.
module hhrf_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_vld,
    input  logic [hhrf_pkg::SQ_W-1:0]  i_sq,
    input  logic [SIDE_W-1:0]          i_side,
    output logic                       o_vld,
    output logic [hhrf_pkg::ROOT_W-1:0] o_root,
    output logic [SIDE_W-1:0]          o_side
);
    import hhrf_pkg::*;

    localparam int REM_W = SQ_W + 2;

    logic [ROOT_W-1:0] r_vld;
    logic [REM_W-1:0]  r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [SIDE_W-1:0] r_side [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
        localparam int B = ROOT_W - 1 - i;
        logic              w_vld_in;
        logic [REM_W-1:0]  w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [REM_W-1:0]  w_trial;

        if (i == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = REM_W'(i_sq);
            assign w_root_in = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[i-1];
            assign w_rem_in  = r_rem[i-1];
            assign w_root_in = r_root[i-1];
            assign w_side_in = r_side[i-1];
        end

        // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b); the two terms never overlap
        assign w_trial = (REM_W'(w_root_in) << (B + 1)) | (REM_W'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= w_vld_in;
            end
            if (w_rem_in >= w_trial) begin
                r_rem[i]  <= w_rem_in - w_trial;
                r_root[i] <= w_root_in | (ROOT_W'(1) << B);
            end else begin
                r_rem[i]  <= w_rem_in;
                r_root[i] <= w_root_in;
            end
            r_side[i] <= w_side_in;
        end
    end

    assign o_vld  = r_vld[ROOT_W-1];
    assign o_root = r_root[ROOT_W-1];
    assign o_side = r_side[ROOT_W-1];

endmodule

// ----- design/hhrf_div.sv -----
// Pipelined restoring divider: floor(num * 2^QUO_W / den) for num < den, one bit a stage.
// Depends on hhrf_pkg.
module hhrf_div #(
    parameter int SIDE_W = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_vld,
    input  logic [hhrf_pkg::ROOT_W-1:0] i_num,
    input  logic [hhrf_pkg::ROOT_W-1:0] i_den,
    input  logic [SIDE_W-1:0]           i_side,
    output logic                        o_vld,
    output logic [hhrf_pkg::QUO_W-1:0]  o_quo,
    output logic [SIDE_W-1:0]           o_side
);
    import hhrf_pkg::*;

    logic [QUO_W-1:0]  r_vld;
    logic [ROOT_W-1:0] r_rem  [QUO_W];
    logic [ROOT_W-1:0] r_den  [QUO_W];
    logic [QUO_W-1:0]  r_quo  [QUO_W];
    logic [SIDE_W-1:0] r_side [QUO_W];

    for (genvar i = 0; i < QUO_W; i++) begin : g_stage
        logic              w_vld_in;
        logic [ROOT_W-1:0] w_rem_in;
        logic [ROOT_W-1:0] w_den_in;
        logic [QUO_W-1:0]  w_quo_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [ROOT_W:0]   w_sh;
        logic              w_bit;

        if (i == 0) begin : g_first
            assign w_vld_in  = i_vld;
            assign w_rem_in  = i_num;
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_vld_in  = r_vld[i-1];
            assign w_rem_in  = r_rem[i-1];
            assign w_den_in  = r_den[i-1];
            assign w_quo_in  = r_quo[i-1];
            assign w_side_in = r_side[i-1];
        end

        assign w_sh  = {w_rem_in, 1'b0};
        assign w_bit = (w_sh >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else begin
                r_vld[i] <= w_vld_in;
            end
            if (w_bit) begin
                r_rem[i] <= ROOT_W'(w_sh - {1'b0, w_den_in});
            end else begin
                r_rem[i] <= ROOT_W'(w_sh);
            end
            r_den[i]  <= w_den_in;
            r_quo[i]  <= {w_quo_in[QUO_W-2:0], w_bit};
            r_side[i] <= w_side_in;
        end
    end

    assign o_vld  = r_vld[QUO_W-1];
    assign o_quo  = r_quo[QUO_W-1];
    assign o_side = r_side[QUO_W-1];

endmodule

// ----- dv/tb.sv -----
// Self-checking bench for half_harmonic_restraint_force: directed table, then random pairs.
// Expected results come from an in-bench fixed-point model; depends on hhrf_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hhrf_pkg::*;

    typedef struct packed {
        logic [47:0] energy;
        logic [47:0] px;
        logic [47:0] py;
        logic [47:0] pz;
        logic        sat;
    } t_restraint;

    typedef struct {
        logic [31:0] k;
        logic [30:0] flat;
        logic [23:0] scale;
        logic [31:0] crd [6];   // first xyz, second xyz
        bit          typed;
        t_restraint  res;
    } t_pair_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic signed [31:0] i_first_x, i_first_y, i_first_z;
    logic signed [31:0] i_second_x, i_second_y, i_second_z;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic        o_done;
    logic [47:0] o_restraint_energy;
    logic signed [47:0] o_push_x, o_push_y, o_push_z;
    logic        o_saturated;

    half_harmonic_restraint_force dut (.*);

    logic [31:0] cur_k;
    logic [30:0] cur_flat;
    logic [23:0] cur_scale;
    t_restraint  pending_res [$];
    t_pair_row   pair_tab [$];
    int          mismatches;
    int          idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    function automatic t_restraint restraint_of(input logic [31:0] crd [6],
            input logic [31:0] k, input logic [30:0] flat, input logic [23:0] scale);
        t_restraint  res;
        logic signed [33:0] d [3];
        logic [32:0]  m [3];
        logic [67:0]  sumsq, base, cc;
        logic [33:0]  root, cand, ex;
        logic [99:0]  kprod;
        logic [63:0]  ratio, kq;
        logic [56:0]  amp;
        logic [120:0] prod;
        logic [72:0]  mag, lim;
        logic [47:0]  push [3];
        res = '0;
        for (int i = 0; i < 3; i++) begin
            d[i] = {{2{crd[i+3][31]}}, crd[i+3]} - {{2{crd[i][31]}}, crd[i]};
            m[i] = d[i][33] ? 33'(-d[i]) : 33'(d[i]);
        end
        sumsq = 68'(m[0]) * m[0] + 68'(m[1]) * m[1] + 68'(m[2]) * m[2];
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            cand = root | (34'd1 << b);
            cc = 68'(cand) * cand;
            if (cc <= sumsq) root = cand;
        end
        ex = '0;
        base = '0;
        ratio = '0;
        if (flat == 0) begin
            base = sumsq;
            ratio = 64'd1 << 30;
        end else if (root > flat) begin
            ex = root - flat;
            base = 68'(ex) * ex;
            ratio = {ex, 30'd0} / 64'(root);
        end
        kprod = 100'(k) * base;
        if ((kprod >> 32) >= (100'd1 << 48)) begin
            res.energy = '1;
            res.sat = 1'b1;
        end else begin
            res.energy = kprod[79:32];
        end
        kq = 64'(k) * 2 * ratio;
        for (int i = 0; i < 3; i++) begin
            amp = 57'(m[i]) * scale;
            prod = 121'(amp) * kq;
            mag = 73'(prod >> 62);
            lim = d[i][33] ? 73'h800000000000 : 73'h7FFFFFFFFFFF;
            if (mag > lim) begin
                mag = lim;
                res.sat = 1'b1;
            end
            push[i] = d[i][33] ? 48'(-mag) : mag[47:0];
        end
        res.px = push[0];
        res.py = push[1];
        res.pz = push[2];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_restraint want;
        if (i_rst_n && o_done) begin
            if (pending_res.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transaction");
            end else begin
                want = pending_res.pop_front();
                if (o_restraint_energy !== want.energy || o_push_x !== want.px
                        || o_push_y !== want.py || o_push_z !== want.pz
                        || o_saturated !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp E=%h x=%h y=%h z=%h s=%b got E=%h x=%h y=%h z=%h s=%b",
                            want.energy, want.px, want.py, want.pz, want.sat,
                            o_restraint_energy, o_push_x, o_push_y, o_push_z, o_saturated);
                end
            end
        end
    end

    // drain the pipeline before touching registers
    task automatic drain();
        start <= 1'b0;
        wait (pending_res.size() == 0);
        repeat (80) @(posedge i_clk);
    endtask

    // leaves valid high; the caller drops it after the last write
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic [31:0] k, input logic [30:0] flat,
            input logic [23:0] scale);
        drain();
        write_reg(CFG_FORCE_CONSTANT, k);
        write_reg(CFG_FLAT_LENGTH, {1'b0, flat});
        write_reg(CFG_FORCE_SCALE, {8'd0, scale});
        i_cfg_valid <= 1'b0;
        cur_k = k;
        cur_flat = flat;
        cur_scale = scale;
    endtask

    task automatic send_pair(input logic [31:0] crd [6], input bit typed,
            input t_restraint res);
        int gap;
        i_first_x  <= crd[0];
        i_first_y  <= crd[1];
        i_first_z  <= crd[2];
        i_second_x <= crd[3];
        i_second_y <= crd[4];
        i_second_z <= crd[5];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        pending_res.push_back(typed ? res
            : restraint_of(crd, cur_k, cur_flat, cur_scale));
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input logic [31:0] k, input logic [30:0] flat,
            input logic [23:0] scale, input logic [31:0] f, input logic [31:0] s,
            input logic [31:0] sx, input bit typed, input t_restraint res);
        t_pair_row row;
        row.k = k;
        row.flat = flat;
        row.scale = scale;
        row.crd = '{f, f, f, sx, s, s};
        row.typed = typed;
        row.res = res;
        pair_tab.push_back(row);
    endtask

    initial begin
        t_restraint  zero_res, max_res, min_res, unit_res;
        logic [31:0] crd [6];
        logic [31:0] k, delta;
        logic [30:0] flat;
        logic [23:0] scale;
        int          kind;
        int          pct [6] = '{0, 69, 13, 69, 0, 13};

        i_rst_n = 1'b0;
        start = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_FORCE_CONSTANT;
        i_cfg_data = '0;
        {i_first_x, i_first_y, i_first_z} = '0;
        {i_second_x, i_second_y, i_second_z} = '0;
        mismatches = 0;
        idle_pct = 0;
        cur_k = '0;
        cur_flat = '0;
        cur_scale = SCALE_ONE;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        zero_res = '0;
        max_res = '{48'hFFFFFFFFFFFF, 48'h7FFFFFFFFFFF, 48'h7FFFFFFFFFFF,
                    48'h7FFFFFFFFFFF, 1'b1};
        min_res = '{48'hFFFFFFFFFFFF, 48'h800000000000, 48'h800000000000,
                    48'h800000000000, 1'b1};
        unit_res = '{48'h10000, 48'h20000, 48'h0, 48'h0, 1'b0};

        // reset values: zero spring constant gives zeros everywhere
        add_row(0, 0, SCALE_ONE, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1, zero_res);
        add_row(0, 0, SCALE_ONE, 0, 0, 0, 1, zero_res);
        add_row(0, 0, SCALE_ONE, 32'h12345, 32'hFFFF0000, 32'h40000, 0, zero_res);
        // largest k and scale, plain harmonic
        add_row('1, 0, '1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, max_res);
        add_row('1, 0, '1, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 1, min_res);
        add_row('1, 0, '1, 32'h55555555, 32'h55555555, 32'h55555555, 1, zero_res);
        add_row('1, 0, '1, 32'h0, 32'h1, 32'hFFFFFFFF, 0, zero_res);
        // k = 1.0, unit distance along x
        add_row(32'h10000, 0, SCALE_ONE, 0, 0, 32'h10000, 1, unit_res);
        add_row(32'h10000, 0, SCALE_ONE, 32'h10000, 32'h20000, 32'h30000, 0, zero_res);
        add_row(32'h10000, 0, SCALE_ONE, 32'hFFFF8000, 32'h1, 32'h7000, 0, zero_res);
        // flat bottom of 2.0: inside, on the edge, beyond
        add_row(32'h10000, 31'h20000, SCALE_ONE, 0, 0, 32'h10000, 1, zero_res);
        add_row(32'h10000, 31'h20000, SCALE_ONE, 0, 0, 32'h20000, 1, zero_res);
        add_row(32'h10000, 31'h20000, SCALE_ONE, 0, 0, 32'h30000, 0, zero_res);
        add_row(32'h10000, 31'h20000, SCALE_ONE, 32'h10000, 32'hFFFE0000, 32'h50000, 0,
                zero_res);
        // largest flat length: zero scale, then largest k and scale
        add_row(32'h10000, 31'h7FFFFFFF, 0, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                zero_res);
        add_row(32'h10000, 31'h7FFFFFFF, 0, 0, 32'h7FFF0000, 32'h7FFF0000, 0, zero_res);
        add_row('1, 31'h7FFFFFFF, '1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 0,
                zero_res);

        foreach (pair_tab[i]) begin
            if (pair_tab[i].k != cur_k || pair_tab[i].flat != cur_flat
                    || pair_tab[i].scale != cur_scale)
                set_config(pair_tab[i].k, pair_tab[i].flat, pair_tab[i].scale);
            send_pair(pair_tab[i].crd, pair_tab[i].typed, pair_tab[i].res);
        end

        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(3))
                0: k = 0;
                1: k = '1;
                2: k = $urandom_range(32'h3FFFF);
                default: k = $urandom;
            endcase
            case ($urandom_range(3))
                0: flat = 0;
                1: flat = '1;
                2: flat = $urandom_range(32'h7FFFF);
                default: flat = $urandom;
            endcase
            case ($urandom_range(3))
                0: scale = 0;
                1: scale = '1;
                2: scale = SCALE_ONE;
                default: scale = $urandom;
            endcase
            if (ph == 0) begin
                k = $urandom_range(32'hFFFFF, 1);
                flat = 0;
            end
            set_config(k, flat, scale);
            idle_pct = pct[ph];
            for (int n = 0; n < 150; n++) begin
                if (ph == 1 && n == 75) drain();
                kind = $urandom_range(3);
                for (int i = 0; i < 3; i++) begin
                    crd[i] = $urandom;
                    case (kind)
                        0: delta = $urandom;
                        1: delta = $urandom_range(32'h3FFFF) - 32'h1FFFF;
                        2: delta = ($urandom_range(3) == 0) ? $urandom_range(3) : 0;
                        default: delta = $urandom_range({1'b0, cur_flat} + 32'h2000)
                                         - ({1'b0, cur_flat} >> 1);
                    endcase
                    crd[i+3] = (kind == 0) ? $urandom : crd[i] + delta;
                end
                send_pair(crd, 0, zero_res);
            end
        end

        start <= 1'b0;
        wait (pending_res.size() == 0);
        repeat (80) @(posedge i_clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
